>>> rtl/i2cbm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the i2c bit-level master
// no dependencies

package i2cbm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam logic [BIT_IDX_W-1:0] MSB_IDX = BIT_IDX_W'(BITS_PER_BYTE - 1);

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_SACK  = 3'd5,
        CMD_RACK  = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } i2cbm_in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } i2cbm_out_t;

    // sequencer state carried from tick to tick
    typedef struct packed {
        cmd_t                 cmd;
        logic [1:0]           step;
        logic [BIT_IDX_W-1:0] bit_idx;
        logic                 head;
        logic [7:0]           shift_out;
        logic [7:0]           shift_in;
        logic                 ack_store;
        logic                 scl;
        logic                 sda;
    } seq_state_t;

endpackage

>>> rtl/i2cbm_step.sv
`timescale 1ns / 1ps
// one bus tick of the i2c master: command capture plus one pin action or sample
// depends on i2cbm_pkg

module i2cbm_step (
    input  i2cbm_pkg::seq_state_t cur_state,
    input  i2cbm_pkg::i2cbm_in_t  tick_in,
    output i2cbm_pkg::seq_state_t nxt_state,
    output i2cbm_pkg::i2cbm_out_t tick_res
);
    import i2cbm_pkg::*;

    seq_state_t st;
    logic       done;

    always_comb begin
        st   = cur_state;
        done = 1'b0;

        // command capture while idle, unused codes ignored
        if (cur_state.cmd == CMD_IDLE &&
            tick_in.req_type inside {[CMD_START:CMD_RACK]}) begin
            st.cmd     = cmd_t'(tick_in.req_type);
            st.step    = 2'd0;
            st.bit_idx = '0;
            st.head    = (tick_in.req_type == CMD_READ);
            if (tick_in.req_type == CMD_WRITE) begin
                st.shift_out = tick_in.tx_byte;
            end else if (tick_in.req_type == CMD_SACK) begin
                st.shift_out = {7'd0, tick_in.ack_level};
            end
            if (tick_in.req_type == CMD_READ) begin
                st.shift_in = 8'd0;
            end
        end

        case (st.cmd)
            CMD_START: begin
                case (st.step)
                    2'd0:    st.sda = 1'b1;
                    2'd1:    st.scl = 1'b1;
                    2'd2:    st.sda = 1'b0;
                    default: begin
                        st.scl = 1'b0;
                        done   = 1'b1;
                    end
                endcase
                st.step = 2'(st.step + 2'd1);
            end
            CMD_STOP: begin
                case (st.step)
                    2'd0:    st.sda = 1'b0;
                    2'd1:    st.scl = 1'b1;
                    default: begin
                        st.sda = 1'b1;
                        done   = 1'b1;
                    end
                endcase
                st.step = 2'(st.step + 2'd1);
            end
            CMD_WRITE: begin
                case (st.step)
                    2'd0: begin
                        st.sda  = st.shift_out[MSB_IDX - st.bit_idx];
                        st.step = 2'd1;
                    end
                    2'd1: begin
                        st.scl  = 1'b1;
                        st.step = 2'd2;
                    end
                    default: begin
                        st.scl     = 1'b0;
                        st.step    = 2'd0;
                        done       = (st.bit_idx == MSB_IDX);
                        st.bit_idx = BIT_IDX_W'(st.bit_idx + 1'b1);
                    end
                endcase
            end
            CMD_READ: begin
                if (st.head) begin
                    // release sda before clocking in the byte
                    st.sda  = 1'b1;
                    st.head = 1'b0;
                end else begin
                    case (st.step)
                        2'd0: begin
                            st.scl  = 1'b1;
                            st.step = 2'd1;
                        end
                        2'd1: begin
                            if (tick_in.sda_in) begin
                                st.shift_in[MSB_IDX - st.bit_idx] = 1'b1;
                            end
                            st.step = 2'd2;
                        end
                        default: begin
                            st.scl     = 1'b0;
                            st.step    = 2'd0;
                            done       = (st.bit_idx == MSB_IDX);
                            st.bit_idx = BIT_IDX_W'(st.bit_idx + 1'b1);
                        end
                    endcase
                end
            end
            CMD_SACK: begin
                case (st.step)
                    2'd0:    st.sda = st.shift_out[0];
                    2'd1:    st.scl = 1'b1;
                    default: begin
                        st.scl = 1'b0;
                        done   = 1'b1;
                    end
                endcase
                st.step = 2'(st.step + 2'd1);
            end
            CMD_RACK: begin
                case (st.step)
                    2'd0:    st.sda = 1'b1;
                    2'd1:    st.scl = 1'b1;
                    2'd2:    st.ack_store = tick_in.sda_in;
                    default: begin
                        st.scl = 1'b0;
                        done   = 1'b1;
                    end
                endcase
                st.step = 2'(st.step + 2'd1);
            end
            default: begin
                // idle: pins hold
            end
        endcase

        if (done) begin
            st.cmd     = CMD_IDLE;
            st.step    = 2'd0;
            st.bit_idx = '0;
            st.head    = 1'b0;
        end
    end

    assign nxt_state = st;

    assign tick_res.scl_out  = st.scl;
    assign tick_res.sda_out  = st.sda;
    assign tick_res.busy_res = (st.cmd != CMD_IDLE);
    assign tick_res.done_res = done;
    assign tick_res.rx_byte  = st.shift_in;
    assign tick_res.ack_seen = st.ack_store;

endmodule

>>> rtl/i2c_bit_level_master.sv
`timescale 1ns / 1ps
// the result of an accepted tick is registered and shows on m_data in the next cycle
// one tick per cycle while m_ready is high; the result register frees as it is taken
// reset (aresetn low, synchronous): idle, scl and sda released, received byte 0, ack 1
// each tick does one pin action or sample; an accepted command acts on that same tick
// depends on i2cbm_pkg and i2cbm_step

module i2c_bit_level_master (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  i2cbm_pkg::i2cbm_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output i2cbm_pkg::i2cbm_out_t m_data
);
    import i2cbm_pkg::*;

    // sequencer state, updated once per accepted tick
    seq_state_t state_reg;
    seq_state_t state_next;

    // result register and its valid flag
    i2cbm_out_t res_next;
    i2cbm_out_t m_data_reg;
    logic       m_valid_reg;

    logic       s_accept;

    // accept a new tick whenever the result register is empty or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // combinational tick logic between state and result registers
    i2cbm_step u_step (
        .cur_state (state_reg),
        .tick_in   (s_data),
        .nxt_state (state_next),
        .tick_res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.cmd       <= CMD_IDLE;
            state_reg.step      <= 2'd0;
            state_reg.bit_idx   <= '0;
            state_reg.head      <= 1'b0;
            state_reg.shift_out <= 8'd0;
            state_reg.shift_in  <= 8'd0;
            state_reg.ack_store <= 1'b1;
            state_reg.scl       <= 1'b1;
            state_reg.sda       <= 1'b1;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a completed command never reports itself still busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.done_res |-> !m_data_reg.busy_res)
        else $error("done flagged while still busy");

    // every accepted tick produces a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted tick produced no result");

    // idle sequencer keeps its counters cleared
    a_idle_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.cmd == CMD_IDLE |-> state_reg.step == 2'd0 && state_reg.bit_idx == '0
        && !state_reg.head)
        else $error("counters not cleared while idle");

    // busy flag of a fresh result tracks the sequencer state
    a_busy_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_data_reg.busy_res == (state_reg.cmd != CMD_IDLE))
        else $error("busy result disagrees with sequencer state");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for i2c_bit_level_master: directed command rows, then
// randomized bus traffic under several idle/stall mixes, checked tick by tick
// depends on i2cbm_pkg and the i2c_bit_level_master rtl

module tb;

    import i2cbm_pkg::*;

    // request code that the block must treat like no request
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // pin levels right after reset, no command running
    localparam i2cbm_out_t LEVELS_AT_RESET = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                              done_res: 1'b0, rx_byte: 8'h00, ack_seen: 1'b1};
    // last tick of a read byte that saw 0xa5, before any read ack has run
    localparam i2cbm_out_t READ_A5_DONE = '{scl_out: 1'b0, sda_out: 1'b1, busy_res: 1'b0,
                                           done_res: 1'b1, rx_byte: 8'hA5, ack_seen: 1'b1};

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    i2cbm_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    i2cbm_out_t m_data;

    // period 4 ns
    always #2 aclk = ~aclk;

    i2c_bit_level_master u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // bus sequencer predictor: its own copy of the block's state
    // ------------------------------------------------------------------
    cmd_t       bus_cmd  = CMD_IDLE;
    int         bus_step = 0;
    logic [7:0] bus_tx   = 8'h00;   // write byte, or the send-ack level in bit 0
    logic [7:0] bus_rx   = 8'h00;
    logic       bus_ack  = 1'b1;
    logic       bus_scl  = 1'b1;
    logic       bus_sda  = 1'b1;
    int         work_ticks = 0;     // ticks on which a command ran a step

    i2cbm_out_t pending_levels [$]; // expected per-tick results, oldest first
    int         err_cnt = 0;

    // idle/stall mix for the current phase, in percent
    int         src_idle_pct  = 0;
    int         snk_stall_pct = 0;
    bit         hold_go       = 1'b0;

    // number of ticks a command occupies the bus
    function automatic int cmd_ticks(input logic [2:0] c);
        case (c)
            CMD_START: return 4;
            CMD_STOP:  return 3;
            CMD_WRITE: return 3 * BITS_PER_BYTE;
            CMD_READ:  return 1 + 3 * BITS_PER_BYTE;
            CMD_SACK:  return 3;
            CMD_RACK:  return 4;
            default:   return 1;
        endcase
    endfunction

    // one bus tick: latch a command if idle, do one pin action or sample, report levels
    function automatic i2cbm_out_t advance_bus(input i2cbm_in_t d);
        int         k;
        logic       fin;
        i2cbm_out_t o;
        fin = 1'b0;
        if (bus_cmd == CMD_IDLE && d.req_type >= CMD_START && d.req_type <= CMD_RACK) begin
            bus_cmd  = cmd_t'(d.req_type);
            bus_step = 0;
            if (bus_cmd == CMD_WRITE)
                bus_tx = d.tx_byte;
            else if (bus_cmd == CMD_SACK)
                bus_tx = {7'd0, d.ack_level};
            if (bus_cmd == CMD_READ)
                bus_rx = 8'h00;
        end
        if (bus_cmd != CMD_IDLE) begin
            case (bus_cmd)
                CMD_START: begin
                    case (bus_step)
                        0:       bus_sda = 1'b1;
                        1:       bus_scl = 1'b1;
                        2:       bus_sda = 1'b0;
                        default: bus_scl = 1'b0;
                    endcase
                end
                CMD_STOP: begin
                    case (bus_step)
                        0:       bus_sda = 1'b0;
                        1:       bus_scl = 1'b1;
                        default: bus_sda = 1'b1;
                    endcase
                end
                CMD_WRITE: begin
                    k = bus_step % 3;
                    if (k == 0)
                        bus_sda = bus_tx[BITS_PER_BYTE - 1 - bus_step / 3];
                    else if (k == 1)
                        bus_scl = 1'b1;
                    else
                        bus_scl = 1'b0;
                end
                CMD_READ: begin
                    // first tick releases sda, then scl high / sample / scl low per bit
                    if (bus_step == 0) begin
                        bus_sda = 1'b1;
                    end else begin
                        k = (bus_step - 1) % 3;
                        if (k == 0)
                            bus_scl = 1'b1;
                        else if (k == 1) begin
                            if (d.sda_in)
                                bus_rx[BITS_PER_BYTE - 1 - (bus_step - 1) / 3] = 1'b1;
                        end else
                            bus_scl = 1'b0;
                    end
                end
                CMD_SACK: begin
                    case (bus_step)
                        0:       bus_sda = bus_tx[0];
                        1:       bus_scl = 1'b1;
                        default: bus_scl = 1'b0;
                    endcase
                end
                CMD_RACK: begin
                    case (bus_step)
                        0:       bus_sda = 1'b1;
                        1:       bus_scl = 1'b1;
                        2:       bus_ack = d.sda_in;
                        default: bus_scl = 1'b0;
                    endcase
                end
                default: ;
            endcase
            bus_step++;
            work_ticks++;
            if (bus_step >= cmd_ticks(bus_cmd)) begin
                fin      = 1'b1;
                bus_cmd  = CMD_IDLE;
                bus_step = 0;
            end
        end
        o.scl_out  = bus_scl;
        o.sda_out  = bus_sda;
        o.busy_res = (bus_cmd != CMD_IDLE);
        o.done_res = fin;
        o.rx_byte  = bus_rx;
        o.ack_seen = bus_ack;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // input side: one tick per transaction, random gaps before each one
    // ------------------------------------------------------------------
    task automatic send_tick(input i2cbm_in_t d, input bit typed, input i2cbm_out_t want);
        i2cbm_out_t pred;
        // gaps: valid drops only between transactions, never while one is offered
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // accepted at this edge: predictor runs for every tick, a typed-in
        // expectation replaces the predicted one where the row carries one
        pred = advance_bus(d);
        pending_levels.push_back(typed ? want : pred);
    endtask

    function automatic i2cbm_in_t rand_tick(input logic [2:0] req);
        i2cbm_in_t d;
        d.req_type  = req;
        d.tx_byte   = 8'($urandom_range(255));
        d.ack_level = 1'($urandom_range(1));
        d.sda_in    = 1'($urandom_range(1));
        return d;
    endfunction

    // a command tick followed by the ticks it needs; filler sometimes carries
    // a stray request that the busy block has to ignore
    task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] tx, input logic ack);
        i2cbm_in_t  d;
        logic [2:0] req;
        d           = rand_tick(cmd);
        d.tx_byte   = tx;
        d.ack_level = ack;
        send_tick(d, 1'b0, '0);
        for (int n = 1; n < cmd_ticks(cmd); n++) begin
            req = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : CMD_IDLE;
            send_tick(rand_tick(req), 1'b0, '0);
        end
    endtask

    // random traffic: mostly complete bus transfers, some noise and idle ticks
    task automatic run_bus_traffic(input int upto);
        int         r;
        logic [7:0] addr;
        while (work_ticks < upto) begin
            r = $urandom_range(99);
            if (r < 12) begin
                // noise: any code at any moment; while a command runs the block ignores it
                send_tick(rand_tick(3'($urandom_range(7))), 1'b0, '0);
            end else if (r < 18) begin
                repeat ($urandom_range(1, 3))
                    send_tick(rand_tick(($urandom_range(1) == 1) ? CMD_IDLE : REQ_UNUSED),
                              1'b0, '0);
            end else begin
                // start, address, ack, up to three data bytes with acks, stop
                addr = 8'($urandom_range(255));
                send_cmd(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
                send_cmd(CMD_WRITE, addr, 1'($urandom_range(1)));
                send_cmd(CMD_RACK, 8'($urandom_range(255)), 1'($urandom_range(1)));
                repeat ($urandom_range(0, 3)) begin
                    if (addr[0]) begin
                        send_cmd(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
                        send_cmd(CMD_SACK, 8'($urandom_range(255)), 1'($urandom_range(1)));
                    end else begin
                        send_cmd(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
                        send_cmd(CMD_RACK, 8'($urandom_range(255)), 1'($urandom_range(1)));
                    end
                end
                send_cmd(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go = 1'b0;
                // long stall counted here so the sender keeps offering ticks
                // and the block backs up into its input
                m_ready <= 1'b0;
                repeat (150)
                    @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // every result transaction is compared with the oldest expectation
    always @(posedge aclk) begin : result_check
        i2cbm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_levels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                err_cnt++;
            end else begin
                want = pending_levels.pop_front();
                check_field("scl_out",  8'(want.scl_out),  8'(m_data.scl_out));
                check_field("sda_out",  8'(want.sda_out),  8'(m_data.sda_out));
                check_field("busy_res", 8'(want.busy_res), 8'(m_data.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(m_data.done_res));
                check_field("rx_byte",  want.rx_byte,      m_data.rx_byte);
                check_field("ack_seen", 8'(want.ack_seen), 8'(m_data.ack_seen));
            end
        end
    end

    // ------------------------------------------------------------------
    // directed rows: one command each, expanded into its ticks
    // ------------------------------------------------------------------
    typedef struct {
        logic [2:0] req;
        logic [7:0] tx;
        logic       ack;
        logic [7:0] sda_bits;   // sda_in per bit slot, msb first
        int         ticks;
        bit         noisy;      // filler ticks carry stray requests
        bit         typed;      // last tick checked against want
        i2cbm_out_t want;
    } seq_row_t;

    localparam int N_ROWS = 18;

    seq_row_t seq_rows [N_ROWS] = '{
        // idle tick straight after reset
        '{CMD_IDLE,   8'h00, 1'b0, 8'h00, 1,  1'b0, 1'b1, LEVELS_AT_RESET},
        // unused request code is ignored
        '{REQ_UNUSED, 8'hFF, 1'b1, 8'hFF, 1,  1'b0, 1'b1, LEVELS_AT_RESET},
        '{CMD_READ,   8'h00, 1'b0, 8'hA5, 25, 1'b0, 1'b1, READ_A5_DONE},
        '{CMD_START,  8'h00, 1'b0, 8'hFF, 4,  1'b0, 1'b0, '0},
        '{CMD_WRITE,  8'hFF, 1'b1, 8'h00, 24, 1'b0, 1'b0, '0},
        '{CMD_RACK,   8'h00, 1'b0, 8'h00, 4,  1'b0, 1'b0, '0},
        // requests while busy must not disturb the write
        '{CMD_WRITE,  8'h00, 1'b0, 8'hFF, 24, 1'b1, 1'b0, '0},
        '{CMD_RACK,   8'hFF, 1'b1, 8'hFF, 4,  1'b0, 1'b0, '0},
        // read byte clears the previously received byte
        '{CMD_READ,   8'hFF, 1'b1, 8'hFF, 25, 1'b1, 1'b0, '0},
        '{CMD_SACK,   8'hFF, 1'b0, 8'h00, 3,  1'b0, 1'b0, '0},
        '{CMD_READ,   8'h00, 1'b0, 8'h00, 25, 1'b0, 1'b0, '0},
        '{CMD_SACK,   8'h00, 1'b1, 8'hFF, 3,  1'b0, 1'b0, '0},
        '{CMD_WRITE,  8'h81, 1'b0, 8'h5A, 24, 1'b0, 1'b0, '0},
        '{CMD_STOP,   8'h00, 1'b0, 8'hFF, 3,  1'b0, 1'b0, '0},
        // idle ticks hold the pin levels
        '{CMD_IDLE,   8'hFF, 1'b1, 8'h00, 2,  1'b0, 1'b0, '0},
        '{CMD_STOP,   8'hFF, 1'b1, 8'h00, 3,  1'b1, 1'b0, '0},
        '{CMD_START,  8'h00, 1'b0, 8'h00, 4,  1'b0, 1'b0, '0},
        '{CMD_SACK,   8'h7E, 1'b0, 8'hFF, 3,  1'b1, 1'b0, '0}
    };

    // watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        i2cbm_in_t d;
        int        idx;

        // single synchronous reset at the start of the run
        repeat (12)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, no idling
        foreach (seq_rows[i]) begin
            for (int t = 0; t < seq_rows[i].ticks; t++) begin
                idx = t / 3;
                if (idx > BITS_PER_BYTE - 1)
                    idx = BITS_PER_BYTE - 1;
                if (t == 0 || !seq_rows[i].noisy)
                    d.req_type = (t == 0) ? seq_rows[i].req : CMD_IDLE;
                else
                    d.req_type = 3'($urandom_range(7));
                d.tx_byte   = seq_rows[i].tx;
                d.ack_level = seq_rows[i].ack;
                d.sda_in    = seq_rows[i].sda_bits[BITS_PER_BYTE - 1 - idx];
                send_tick(d, seq_rows[i].typed && (t == seq_rows[i].ticks - 1),
                          seq_rows[i].want);
            end
        end

        // random phases: no idling with one long hold-off, sender idle,
        // receiver stalling, both
        hold_go = 1'b1;
        run_bus_traffic(work_ticks + 250);
        src_idle_pct  = 55;
        snk_stall_pct = 0;
        run_bus_traffic(work_ticks + 250);
        src_idle_pct  = 0;
        snk_stall_pct = 55;
        run_bus_traffic(work_ticks + 250);
        src_idle_pct  = 38;
        snk_stall_pct = 38;
        run_bus_traffic(work_ticks + 250);

        // drain: every expected tick back, then a wait for strays
        s_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge aclk);
        repeat (8)
            @(posedge aclk);

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
